// ===== rtl/core/fxalu_pkg.sv =====
// ----------------------------------------------------------------------------
// fxalu_pkg
// Opcodes and pipeline payload type shared by the fixed-point ALU files.
// ----------------------------------------------------------------------------
package fxalu_pkg;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} opcode_t;

	localparam int unsigned OUT_WIDTH = 32;

	// One transaction on its way to the output, beside the divider.
	typedef struct packed {
		logic                 valid;
		logic                 is_div;
		logic                 dz;
		logic                 cmp;
		logic [OUT_WIDTH-1:0] res;
	} stage_t;

endpackage

// ===== rtl/core/fxalu_div.sv =====
// ----------------------------------------------------------------------------
// fxalu_div
// Pipelined restoring divider: (a << FB) / b, truncated toward zero,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module fxalu_div #(
	parameter int DW = 32,
	parameter int FB = 8
) (
	input  logic                 clk,
	input  logic signed [DW-1:0] a,
	input  logic signed [DW-1:0] b,
	output logic signed [DW-1:0] quot
);

	localparam int N = DW + FB;

	logic [DW-1:0] rem_s [0:N];
	logic [N-1:0]  nq_s  [0:N];
	logic [DW-1:0] d_s   [0:N];
	logic          neg_s [0:N];

	logic [DW-1:0] amag;
	logic [DW-1:0] bmag;
	logic [N-1:0]  qfix;

	assign amag = a[DW-1] ? (~a + 1'b1) : a;
	assign bmag = b[DW-1] ? (~b + 1'b1) : b;

	always_ff @(posedge clk) begin
		rem_s[0] <= '0;
		nq_s[0]  <= N'(amag) << FB;
		d_s[0]   <= bmag;
		neg_s[0] <= a[DW-1] ^ b[DW-1];
	end

	// The dividend shifts out at the top of nq while quotient bits enter below.
	for (genvar i = 1; i <= N; i++) begin : g_stage
		logic [DW:0] shifted;
		logic [DW:0] trial;

		assign shifted = {rem_s[i-1], nq_s[i-1][N-1]};
		assign trial   = shifted - {1'b0, d_s[i-1]};

		always_ff @(posedge clk) begin
			if (!trial[DW]) begin
				rem_s[i] <= trial[DW-1:0];
			end else begin
				rem_s[i] <= shifted[DW-1:0];
			end
			nq_s[i]  <= {nq_s[i-1][N-2:0], ~trial[DW]};
			d_s[i]   <= d_s[i-1];
			neg_s[i] <= neg_s[i-1];
		end
	end

	assign qfix = neg_s[N] ? (~nq_s[N] + 1'b1) : nq_s[N];

	always_ff @(posedge clk) begin
		quot <= qfix[DW-1:0];
	end

endmodule

// ===== rtl/core/fixed_point_q24_8_alu_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit
// Signed fixed-point ALU with a fully pipelined multiplier and divider.
// ----------------------------------------------------------------------------
// A transaction is accepted on every cycle in which start is high; busy stays
// low. Each transaction produces one result, marked by done for one cycle,
// in order. The restoring divider resolves one quotient bit per pipeline
// stage; all other operations are delayed to match it.
module fixed_point_q24_8_alu_unit #(
	parameter int FRAC_BITS  = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  opcode,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        done,
	output logic [31:0] result,
	output logic        compare_true,
	output logic        divide_by_zero
);

	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int N  = DW + FB;

	logic                 v_s1;
	fxalu_pkg::opcode_t   op_s1;
	logic signed [DW-1:0] a_s1;
	logic signed [DW-1:0] b_s1;

	logic                   v_s2;
	fxalu_pkg::opcode_t     op_s2;
	logic signed [DW-1:0]   res_s2;
	logic                   cmp_s2;
	logic                   dz_s2;
	logic signed [2*DW-1:0] prod_s2;

	logic signed [DW-1:0]   res_c;
	logic                   cmp_c;
	logic signed [2*DW-1:0] prod_c;
	logic signed [2*DW-1:0] prod_sh;
	logic signed [DW-1:0]   res2_c;

	fxalu_pkg::stage_t line_s [0:N];
	logic signed [DW-1:0] quot;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= fxalu_pkg::opcode_t'(opcode);
		a_s1  <= operand_a[DW-1:0];
		b_s1  <= operand_b[DW-1:0];
	end

	always_comb begin
		res_c  = '0;
		cmp_c  = 1'b0;
		prod_c = a_s1 * b_s1;
		case (op_s1)
			fxalu_pkg::OP_ADD:      res_c = a_s1 + b_s1;
			fxalu_pkg::OP_SUB:      res_c = a_s1 - b_s1;
			fxalu_pkg::OP_GT:       cmp_c = a_s1 > b_s1;
			fxalu_pkg::OP_LT:       cmp_c = a_s1 < b_s1;
			fxalu_pkg::OP_GE:       cmp_c = a_s1 >= b_s1;
			fxalu_pkg::OP_LE:       cmp_c = a_s1 <= b_s1;
			fxalu_pkg::OP_EQ:       cmp_c = a_s1 == b_s1;
			fxalu_pkg::OP_NE:       cmp_c = a_s1 != b_s1;
			fxalu_pkg::OP_MIN:      res_c = (a_s1 < b_s1) ? a_s1 : b_s1;
			fxalu_pkg::OP_MAX:      res_c = (a_s1 > b_s1) ? a_s1 : b_s1;
			fxalu_pkg::OP_INC:      res_c = a_s1 + 1'b1;
			fxalu_pkg::OP_DEC:      res_c = a_s1 - 1'b1;
			fxalu_pkg::OP_FROM_INT: res_c = a_s1 << FB;
			fxalu_pkg::OP_TO_INT:   res_c = a_s1 >>> FB;
			default:                res_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		res_s2  <= res_c;
		cmp_s2  <= cmp_c;
		dz_s2   <= (op_s1 == fxalu_pkg::OP_DIV) && (b_s1 == '0);
		prod_s2 <= prod_c;
	end

	assign prod_sh = prod_s2 >>> FB;
	assign res2_c  = (op_s2 == fxalu_pkg::OP_MUL) ? prod_sh[DW-1:0] : res_s2;

	// The delay line keeps every transaction aligned with the divider output.
	// Flags only travel with a valid transaction so idle cycles stay quiet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_s[0] <= '0;
		end else begin
			line_s[0].valid  <= v_s2;
			line_s[0].is_div <= v_s2 && (op_s2 == fxalu_pkg::OP_DIV);
			line_s[0].dz     <= v_s2 && dz_s2;
			line_s[0].cmp    <= v_s2 && cmp_s2;
			line_s[0].res    <= fxalu_pkg::OUT_WIDTH'(res2_c);
		end
	end

	for (genvar i = 1; i <= N; i++) begin : g_line
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				line_s[i] <= '0;
			end else begin
				line_s[i] <= line_s[i-1];
			end
		end
	end

	fxalu_div #(
		.DW(DW),
		.FB(FB)
	) u_div (
		.clk (clk),
		.a   (a_s1),
		.b   (b_s1),
		.quot(quot)
	);

	assign done           = line_s[N].valid;
	assign compare_true   = line_s[N].cmp;
	assign divide_by_zero = line_s[N].dz;

	always_comb begin
		if (line_s[N].is_div && !line_s[N].dz) begin
			result = fxalu_pkg::OUT_WIDTH'(quot);
		end else begin
			result = line_s[N].res;
		end
	end

	a_dz_done: assert property (@(posedge clk) disable iff (!arst_n)
		divide_by_zero |-> done && result == '0)
		else $error("divide by zero flagged without a zero result");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		compare_true |-> done && result == '0 && !divide_by_zero)
		else $error("comparison result carries a nonzero word");

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !busy)
		else $error("pipeline refused a transaction");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed and random operations into the ALU and compares every
// result, in order, against a hard-coded value or a behavioral predictor of the Q24.8 arithmetic.
// ----------------------------------------------------------------------------
module tb;

	localparam int FRAC = 8;
	localparam int LATENCY = 43;

	typedef struct {
		logic [31:0] res;
		logic        cmp;
		logic        dz;
	} alu_out_t;

	typedef struct {
		fxalu_pkg::opcode_t op;
		logic [31:0]        a;
		logic [31:0]        b;
		logic               known;
		alu_out_t           want;
	} vec_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  opcode;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic        done;
	logic [31:0] result;
	logic        compare_true;
	logic        divide_by_zero;

	alu_out_t pending_q[$];
	int       errors;
	int       n_sent;
	int       n_checked;
	vec_t     vectors[$];

	fixed_point_q24_8_alu_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
		.done(done), .result(result), .compare_true(compare_true),
		.divide_by_zero(divide_by_zero)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic alu_out_t alu_predict(fxalu_pkg::opcode_t op, logic [31:0] a,
			logic [31:0] b);
		alu_out_t o;
		logic signed [31:0] sa;
		logic signed [31:0] sb;
		logic signed [63:0] wide;
		sa = a;
		sb = b;
		o.res = '0;
		o.cmp = 1'b0;
		o.dz = 1'b0;
		case (op)
			fxalu_pkg::OP_ADD: o.res = a + b;
			fxalu_pkg::OP_SUB: o.res = a - b;
			fxalu_pkg::OP_MUL: begin
				wide = 64'(sa) * 64'(sb);
				o.res = 32'(wide >>> FRAC);
			end
			fxalu_pkg::OP_DIV: begin
				if (b == 0) begin
					o.dz = 1'b1;
				end else begin
					// The 64-bit quotient truncates toward zero, then wraps.
					wide = (64'(sa) <<< FRAC) / 64'(sb);
					o.res = wide[31:0];
				end
			end
			fxalu_pkg::OP_GT: o.cmp = sa > sb;
			fxalu_pkg::OP_LT: o.cmp = sa < sb;
			fxalu_pkg::OP_GE: o.cmp = sa >= sb;
			fxalu_pkg::OP_LE: o.cmp = sa <= sb;
			fxalu_pkg::OP_EQ: o.cmp = sa == sb;
			fxalu_pkg::OP_NE: o.cmp = sa != sb;
			fxalu_pkg::OP_MIN: o.res = (sa < sb) ? a : b;
			fxalu_pkg::OP_MAX: o.res = (sa > sb) ? a : b;
			fxalu_pkg::OP_INC: o.res = a + 32'd1;
			fxalu_pkg::OP_DEC: o.res = a - 32'd1;
			fxalu_pkg::OP_FROM_INT: o.res = a << FRAC;
			default: o.res = sa >>> FRAC;
		endcase
		return o;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return 32'($signed($urandom_range(0, 2047)) - 1024);
			4: return 32'($signed($urandom_range(0, 2)) - 1) << FRAC;
			default: return $urandom;
		endcase
	endfunction

	function automatic vec_t mk(fxalu_pkg::opcode_t op, logic [31:0] a, logic [31:0] b,
			logic known, logic [31:0] r, logic c, logic z);
		vec_t v;
		v.op = op;
		v.a = a;
		v.b = b;
		v.known = known;
		v.want.res = r;
		v.want.cmp = c;
		v.want.dz = z;
		return v;
	endfunction

	task automatic send_op(vec_t v, bit allow_gap);
		int gap;
		if (allow_gap && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= v.op;
		operand_a <= v.a;
		operand_b <= v.b;
		pending_q.push_back(v.known ? v.want : alu_predict(v.op, v.a, v.b));
		@(posedge clk);
		while (busy) @(posedge clk);
		n_sent++;
	endtask

	// Results are sampled at the edge that ends their strobe cycle.
	always @(posedge clk) begin
		alu_out_t w;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result with no transaction pending: %h", $time, result);
				errors++;
			end else begin
				w = pending_q.pop_front();
				n_checked++;
				if (result !== w.res) begin
					$display("%0t: result expected %h actual %h", $time, w.res, result);
					errors++;
				end
				if (compare_true !== w.cmp) begin
					$display("%0t: compare_true expected %b actual %b", $time, w.cmp,
						compare_true);
					errors++;
				end
				if (divide_by_zero !== w.dz) begin
					$display("%0t: divide_by_zero expected %b actual %b", $time, w.dz,
						divide_by_zero);
					errors++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		vec_t v;
		int waited;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = fxalu_pkg::OP_ADD;
		operand_a = '0;
		operand_b = '0;

		vectors.push_back(mk(fxalu_pkg::OP_ADD, 32'h7fff_ffff, 32'h1, 1,
			32'h8000_0000, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_SUB, 32'h8000_0000, 32'h1, 1,
			32'h7fff_ffff, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_MUL, 32'h0000_0100, 32'h0000_0100, 1,
			32'h100, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 0,
			0, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0001, 1,
			32'hffff_ffff, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_DIV, 32'h0000_1234, 32'h0, 1,
			32'h0, 0, 1));
		vectors.push_back(mk(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ff00, 0,
			0, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0,
			0, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_DIV, 32'hffff_ff00, 32'h0000_0300, 0,
			0, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_DIV, 32'h7fff_ffff, 32'h0000_0001, 0,
			0, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_GT, 32'h7fff_ffff, 32'h8000_0000, 1,
			32'h0, 1, 0));
		vectors.push_back(mk(fxalu_pkg::OP_LT, 32'h7fff_ffff, 32'h8000_0000, 1,
			32'h0, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_GE, 32'h5, 32'h5, 1, 32'h0, 1, 0));
		vectors.push_back(mk(fxalu_pkg::OP_LE, 32'h8000_0000, 32'h8000_0000, 1,
			32'h0, 1, 0));
		vectors.push_back(mk(fxalu_pkg::OP_EQ, 32'hffff_ffff, 32'hffff_ffff, 1,
			32'h0, 1, 0));
		vectors.push_back(mk(fxalu_pkg::OP_NE, 32'hffff_ffff, 32'hffff_ffff, 1,
			32'h0, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_MIN, 32'h8000_0000, 32'h7fff_ffff, 1,
			32'h8000_0000, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff, 1,
			32'h7fff_ffff, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_MIN, 32'h42, 32'h42, 1, 32'h42, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_INC, 32'h7fff_ffff, 32'hdead_beef, 1,
			32'h8000_0000, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_DEC, 32'h8000_0000, 32'h0, 1,
			32'h7fff_ffff, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_FROM_INT, 32'h00ff_ffff, 32'h0, 1,
			32'hffff_ff00, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_TO_INT, 32'hffff_ff80, 32'h0, 1,
			32'hffff_ffff, 0, 0));
		vectors.push_back(mk(fxalu_pkg::OP_TO_INT, 32'h8000_0000, 32'hffff_ffff, 1,
			32'hff80_0000, 0, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i]) send_op(vectors[i], 1'b0);

		for (int i = 0; i < 800; i++) begin
			if (i == 400) begin
				// Drain the pipeline completely once mid-run.
				start <= 1'b0;
				while (pending_q.size() != 0) @(posedge clk);
			end
			v.op = fxalu_pkg::opcode_t'($urandom_range(0, 15));
			v.a = rand_operand();
			v.b = ($urandom_range(0, 15) == 0) ? 32'h0 : rand_operand();
			v.known = 1'b0;
			send_op(v, i < 700);
		end
		start <= 1'b0;

		waited = 0;
		while (pending_q.size() != 0 && waited < 10 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY) @(posedge clk);

		$display("Sent %0d operations over all 16 opcodes, %0d results checked.",
			n_sent, n_checked);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/fxalu_pkg.sv
rtl/core/fxalu_div.sv
rtl/core/fixed_point_q24_8_alu_unit.sv
dv/tb.sv
